@@ hw/rtl/dfr_pkg.sv @@
// Shared constants and types for the XOR-checked frame deframer.
package dfr_pkg;

    localparam logic [7:0] SYNC_BYTE          = 8'hA6;
    localparam int         BODY_LENGTH        = 8;
    localparam int         BODY_IDX_W         = $clog2(BODY_LENGTH);
    localparam int         COUNT_W            = 4;
    localparam int         HEADER_LENGTH_DEF  = 3;

    typedef struct packed {
        logic [3:0]  dst_dev;
        logic [3:0]  src_dev;
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [7:0]  desk_id;
        logic [7:0]  card_id;
        logic [23:0] reserved_bytes;
    } dfr_result_t;

endpackage

@@ hw/rtl/dfr_in_stage.sv @@
// Input register: holds one received byte until the parser takes it.
module dfr_in_stage
    import dfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       advance,
    output logic       stage_valid,
    output logic [7:0] stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready    = !valid_reg || advance;
    assign valid_next  = in_ready ? in_valid : valid_reg;
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

@@ hw/rtl/dfr_parser.sv @@
// Frame parser: sync hunt, body capture, running XOR and check compare.
module dfr_parser
    import dfr_pkg::*;
#(
    parameter int HEADER_LENGTH = HEADER_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data,
    output logic        emit,
    output dfr_result_t result
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_BODY  = 2'd1,
        PH_CHECK = 2'd2
    } phase_t;

    localparam logic [COUNT_W-1:0] HDR_LEN  = COUNT_W'(HEADER_LENGTH);
    localparam logic [COUNT_W-1:0] BODY_LEN = COUNT_W'(BODY_LENGTH);

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0]   count_inc;
    logic [7:0]           xor_reg, xor_next;
    logic [7:0]           body_reg [BODY_LENGTH];
    logic                 store_we;
    logic [BODY_IDX_W-1:0] store_idx;

    assign count_inc = byte_count_reg + COUNT_W'(1);
    assign store_idx = byte_count_reg[BODY_IDX_W-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        store_we        = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (step)
                begin
                    if (data == SYNC_BYTE)
                    begin
                        xor_next = xor_reg ^ data;
                        if (count_inc >= HDR_LEN)
                        begin
                            phase_next      = PH_BODY;
                            byte_count_next = '0;
                        end
                        else
                        begin
                            byte_count_next = count_inc;
                        end
                    end
                    else
                    begin
                        byte_count_next = '0;
                        xor_next        = '0;
                    end
                end
            end
            PH_BODY:
            begin
                if (step)
                begin
                    store_we        = 1'b1;
                    xor_next        = xor_reg ^ data;
                    byte_count_next = count_inc;
                    if (count_inc >= BODY_LEN)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK:
            begin
                // pass or fail, the frame ends here
                if (step)
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = '0;
                    xor_next        = '0;
                end
            end
            default:
            begin
                if (step)
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = '0;
                    xor_next        = '0;
                end
            end
        endcase
    end

    assign emit = (phase_reg == PH_CHECK) && (data == xor_reg);

    assign result.dst_dev        = body_reg[0][3:0];
    assign result.src_dev        = body_reg[0][7:4];
    assign result.seq            = body_reg[1];
    assign result.cmd            = body_reg[2];
    assign result.desk_id        = body_reg[3];
    assign result.card_id        = body_reg[4];
    assign result.reserved_bytes = {body_reg[7], body_reg[6], body_reg[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= '0;
            xor_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            xor_reg        <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            body_reg[store_idx] <= data;
        end
    end

    a_check_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_CHECK) |=> (phase_reg == PH_HUNT && xor_reg == 8'd0
                                             && byte_count_reg == '0))
        else $error("parser did not restart after check byte");

    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (byte_count_reg < HDR_LEN))
        else $error("sync count reached header length while hunting");

    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (byte_count_reg < BODY_LEN))
        else $error("body count out of range");

    a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(xor_reg) && $stable(byte_count_reg)))
        else $error("parser state moved without a byte");

endmodule

@@ hw/rtl/dfr_out_stage.sv @@
// Result register: holds one decoded frame until the receiver takes it.
module dfr_out_stage
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dfr_result_t result,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output dfr_result_t held
);

    logic        valid_reg;
    logic        valid_next;
    dfr_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign held       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ hw/rtl/xor_checked_frame_deframer_top.sv @@
// Top level of the XOR-checked frame deframer.
//
// Input channel (in_valid/in_ready, byte_in): one received byte per item.
// A frame is HEADER_LENGTH sync bytes of 0xA6, eight body bytes and one
// check byte equal to the XOR of all sync and body bytes. A non-sync byte
// while hunting restarts the hunt.
// Output channel (out_valid/out_ready): one item per frame whose check byte
// matches, carrying the decoded body fields; failed frames give nothing.
// Path: a check byte is registered in the input register, then parser
// logic compares it and loads the result register, which offers the
// result to the receiver.
// Throughput: one byte per cycle unless stalled, one parser step per byte.
// When the receiver stalls, bytes that give no result keep flowing; only a
// passing check byte waits in the input register until the result register
// frees, and meanwhile in_ready stays low behind it.
// Reset: parser returns to hunting with count and XOR cleared, both
// registers empty.
module xor_checked_frame_deframer_top
    import dfr_pkg::*;
#(
    parameter int HEADER_LENGTH = HEADER_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  dst_dev,
    output logic [3:0]  src_dev,
    output logic [7:0]  seq,
    output logic [7:0]  cmd,
    output logic [7:0]  desk_id,
    output logic [7:0]  card_id,
    output logic [23:0] reserved_bytes
);

    logic        stage_valid;
    logic [7:0]  stage_byte;
    logic        advance;
    logic        emit;
    logic        can_load;
    logic        load;
    dfr_result_t parsed;
    dfr_result_t held;

    assign advance = stage_valid && (!emit || can_load);
    assign load    = advance && emit;

    dfr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    dfr_parser #(
        .HEADER_LENGTH (HEADER_LENGTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .data   (stage_byte),
        .emit   (emit),
        .result (parsed)
    );

    dfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (parsed),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign dst_dev        = held.dst_dev;
    assign src_dev        = held.src_dev;
    assign seq            = held.seq;
    assign cmd            = held.cmd;
    assign desk_id        = held.desk_id;
    assign card_id        = held.card_id;
    assign reserved_bytes = held.reserved_bytes;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid || out_ready))
        else $error("result register overwritten while stalled");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !advance) |=> (stage_valid && $stable(stage_byte)))
        else $error("stalled input byte lost");

endmodule
